@@ rtl/pfs_pkg.sv @@
package pfs_pkg;

    // Default number of ports that the counter memory holds.
    localparam int DEF_NUM_PORTS = 8;

    // Counters kept for each port, and the offset of each transmit/receive pair.
    localparam int CNT_PER_PORT = 20;
    localparam logic [4:0] K_PACKETS = 5'd0;
    localparam logic [4:0] K_BYTES   = 5'd2;
    localparam logic [4:0] K_ERRORS  = 5'd4;
    localparam logic [4:0] K_DROPPED = 5'd6;
    localparam logic [4:0] K_ARP     = 5'd8;
    localparam logic [4:0] K_IPV4    = 5'd10;
    localparam logic [4:0] K_IPV6    = 5'd12;
    localparam logic [4:0] K_ICMP    = 5'd14;
    localparam logic [4:0] K_UDP     = 5'd16;
    localparam logic [4:0] K_TCP     = 5'd18;

    // Frame layout and protocol codes.
    localparam logic [15:0] ETH_ARP   = 16'h0806;
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86dd;
    localparam logic [15:0] POS_ETH_HI   = 16'd12;
    localparam logic [15:0] POS_ETH_LO   = 16'd13;
    localparam logic [15:0] POS_V4_PROTO = 16'd23;
    localparam logic [15:0] POS_V6_NEXT  = 16'd20;
    localparam logic [15:0] LEN_L2_MIN   = 16'd14;
    localparam logic [15:0] LEN_V4_MIN   = 16'd34;
    localparam logic [15:0] LEN_V6_MIN   = 16'd54;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_ICMP6  = 8'd58;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    // Request kinds.
    typedef enum logic [1:0] {
        MODE_FRAME = 2'd0,
        MODE_ERROR = 2'd1,
        MODE_DROP  = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    // One counter memory operation: an increment, or a read that yields a result.
    typedef struct packed {
        logic        valid;
        logic        is_read;
        logic        zero;
        logic        status;
        logic [15:0] amount;
    } t_op_ctl;

    // Result of a counter read, leaving the counter memory.
    typedef struct packed {
        logic        valid;
        logic        status;
        logic [63:0] value;
    } t_result;

    // Flat counter index of a counter kind on a port.
    function automatic int cnt_index(input logic [2:0] port, input logic [4:0] kind);
        return int'(port) * CNT_PER_PORT + int'(kind);
    endfunction

endpackage

@@ rtl/per_port_frame_statistics_top.sv @@
// Per-port frame statistics: twenty wrapping 64-bit counters per port (packets, bytes,
// errors, drops, ARP, IPv4, IPv6, ICMP, UDP, TCP, each for transmit and receive), held
// in one single-port-write memory of 20*NUM_PORTS entries that is updated by
// read-modify-write with forwarding. After reset a clearing pass zeroes the memory;
// meanwhile no request is accepted (register writes still are). Frame bytes, errors,
// drops and reads are taken one per cycle when not stalled. The last byte of a frame
// issues up to four counter updates through the single memory port; while they are
// pending only requests that need no counter update are taken. Read results queue in
// a four-entry buffer; reads stall once it and the one read in flight would fill it.
// Register active_ports is at byte address 0.
module per_port_frame_statistics_top #(
    parameter int NUM_PORTS = pfs_pkg::DEF_NUM_PORTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_port_index,
    input  logic        i_direction,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [4:0]  i_counter_select,

    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [63:0] o_read_value,
    output logic        o_read_status,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfs_pkg::*;

    localparam int ADDR_W = $clog2(NUM_PORTS * CNT_PER_PORT);
    localparam logic REG_ACTIVE_PORTS = 1'b0;
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);

    // Register port.
    logic [3:0] r_active_ports;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_ports <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_PORTS)) begin
            r_active_ports <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE_PORTS) ? {28'd0, r_active_ports} : 32'd0;

    // Request decode.
    t_mode mode;
    logic  active;
    logic  needs_op;
    logic  accept;
    logic  rx;
    logic  clearing;

    logic              r_rd_inflight;
    logic [RES_PTR_W:0] r_res_count;
    logic              res_room;

    logic [2:0] r_seq_pend;

    always_comb begin
        mode     = t_mode'(i_mode);
        active   = ({1'b0, i_port_index} < r_active_ports) && (int'(i_port_index) < NUM_PORTS);
        rx       = !i_direction;
        needs_op = (mode == MODE_READ) || (active && ((mode != MODE_FRAME) || i_last_byte));
        res_room = (r_res_count + {{RES_PTR_W{1'b0}}, r_rd_inflight})
                   < (RES_PTR_W + 1)'(RES_DEPTH);
        o_ready  = !clearing && ((r_seq_pend == 3'b000) || !needs_op)
                   && ((mode != MODE_READ) || res_room);
        accept   = i_valid && o_ready;
    end

    // Frame tracking: position, EtherType and protocol byte of the frame in progress.
    logic [15:0] r_byte_pos;
    logic [15:0] r_eth;
    logic [7:0]  r_proto;
    logic [15:0] count;
    logic [15:0] eth_new;
    logic [7:0]  proto_new;
    logic [7:0]  proto_eff;
    logic        class_v;
    logic [4:0]  class_kind;
    logic        proto_v;
    logic [4:0]  proto_kind;
    logic        frame_byte;

    always_comb begin
        frame_byte = accept && (mode == MODE_FRAME) && active;
        count      = (r_byte_pos != 16'hFFFF) ? r_byte_pos + 16'd1 : r_byte_pos;
        eth_new    = r_eth;
        proto_new  = r_proto;
        if (r_byte_pos == POS_ETH_HI) begin
            eth_new[15:8] = i_data_byte;
        end else if (r_byte_pos == POS_ETH_LO) begin
            eth_new[7:0] = i_data_byte;
        end else if ((r_byte_pos == POS_V4_PROTO) && (r_eth == ETH_IPV4)) begin
            proto_new = i_data_byte;
        end else if ((r_byte_pos == POS_V6_NEXT) && (r_eth == ETH_IPV6)) begin
            proto_new = i_data_byte;
        end

        // Classification of the finished frame.
        class_v    = 1'b0;
        class_kind = K_ARP;
        proto_eff  = 8'd0;
        if (count >= LEN_L2_MIN) begin
            if (eth_new == ETH_ARP) begin
                class_v = 1'b1;
            end else if (eth_new == ETH_IPV4) begin
                class_v    = 1'b1;
                class_kind = K_IPV4;
                if (count >= LEN_V4_MIN) begin
                    proto_eff = proto_new;
                end
            end else if (eth_new == ETH_IPV6) begin
                class_v    = 1'b1;
                class_kind = K_IPV6;
                if (count >= LEN_V6_MIN) begin
                    proto_eff = proto_new;
                end
            end
        end
        proto_v    = 1'b1;
        proto_kind = K_ICMP;
        if ((proto_eff == PROTO_ICMP) || (proto_eff == PROTO_ICMP6)) begin
            proto_kind = K_ICMP;
        end else if (proto_eff == PROTO_TCP) begin
            proto_kind = K_TCP;
        end else if (proto_eff == PROTO_UDP) begin
            proto_kind = K_UDP;
        end else begin
            proto_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_eth      <= '0;
            r_proto    <= '0;
        end else if (frame_byte) begin
            if (i_last_byte) begin
                r_byte_pos <= '0;
                r_eth      <= '0;
                r_proto    <= '0;
            end else begin
                r_byte_pos <= count;
                r_eth      <= eth_new;
                r_proto    <= proto_new;
            end
        end
    end

    // End-of-frame sequencer: bytes, class and protocol updates follow the packet update.
    logic [2:0]  n_seq_pend;
    logic [2:0]  r_seq_port;
    logic        r_seq_rx;
    logic [15:0] r_seq_len;
    logic [4:0]  r_seq_class_kind;
    logic [4:0]  r_seq_proto_kind;

    t_op_ctl           op_ctl;
    logic [ADDR_W-1:0] op_addr;
    logic              sel_ok;

    always_comb begin
        op_ctl     = '0;
        op_addr    = '0;
        n_seq_pend = r_seq_pend;
        sel_ok     = active && (int'(i_counter_select) < CNT_PER_PORT);
        if (r_seq_pend != 3'b000) begin
            op_ctl.valid  = 1'b1;
            op_ctl.amount = 16'd1;
            if (r_seq_pend[0]) begin
                op_ctl.amount = r_seq_len;
                op_addr = ADDR_W'(cnt_index(r_seq_port, 5'(K_BYTES + {4'd0, r_seq_rx})));
                n_seq_pend[0] = 1'b0;
            end else if (r_seq_pend[1]) begin
                op_addr = ADDR_W'(cnt_index(r_seq_port,
                                            5'(r_seq_class_kind + {4'd0, r_seq_rx})));
                n_seq_pend[1] = 1'b0;
            end else begin
                op_addr = ADDR_W'(cnt_index(r_seq_port,
                                            5'(r_seq_proto_kind + {4'd0, r_seq_rx})));
                n_seq_pend[2] = 1'b0;
            end
        end else if (accept && needs_op) begin
            op_ctl.valid  = 1'b1;
            op_ctl.amount = 16'd1;
            unique case (mode)
                MODE_READ: begin
                    op_ctl.is_read = 1'b1;
                    op_ctl.zero    = !sel_ok;
                    op_ctl.status  = !active;
                    if (sel_ok) begin
                        op_addr = ADDR_W'(cnt_index(i_port_index, i_counter_select));
                    end
                end
                MODE_ERROR: begin
                    op_addr = ADDR_W'(cnt_index(i_port_index, 5'(K_ERRORS + {4'd0, rx})));
                end
                MODE_DROP: begin
                    op_addr = ADDR_W'(cnt_index(i_port_index, 5'(K_DROPPED + {4'd0, rx})));
                end
                MODE_FRAME: begin
                    op_addr = ADDR_W'(cnt_index(i_port_index, 5'(K_PACKETS + {4'd0, rx})));
                    n_seq_pend = {proto_v && class_v, class_v, 1'b1};
                end
                default: begin
                    op_ctl = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_pend    <= '0;
            r_rd_inflight <= 1'b0;
        end else begin
            r_seq_pend    <= n_seq_pend;
            r_rd_inflight <= op_ctl.valid && op_ctl.is_read;
        end
        if (frame_byte && i_last_byte) begin
            r_seq_port       <= i_port_index;
            r_seq_rx         <= rx;
            r_seq_len        <= count;
            r_seq_class_kind <= class_kind;
            r_seq_proto_kind <= proto_kind;
        end
    end

    // Counter memory with its update stage.
    t_result result;

    pfs_counter_bank #(
        .NUM_PORTS (NUM_PORTS)
    ) u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_ctl   (op_ctl),
        .i_op_addr  (op_addr),
        .o_result   (result),
        .o_clearing (clearing)
    );

    // Result queue toward the output channel.
    logic [63:0]          r_res_value  [RES_DEPTH];
    logic                 r_res_status [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_res_wr;
    logic [RES_PTR_W-1:0] r_res_rd;
    logic                 res_pop;

    assign o_res_valid   = (r_res_count != '0);
    assign res_pop       = o_res_valid && i_res_ready;
    assign o_read_value  = r_res_value[r_res_rd];
    assign o_read_status = r_res_status[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_count <= '0;
            r_res_wr    <= '0;
            r_res_rd    <= '0;
        end else begin
            if (result.valid) begin
                r_res_wr <= r_res_wr + 1'b1;
            end
            if (res_pop) begin
                r_res_rd <= r_res_rd + 1'b1;
            end
            if (result.valid && !res_pop) begin
                r_res_count <= r_res_count + 1'b1;
            end else if (!result.valid && res_pop) begin
                r_res_count <= r_res_count - 1'b1;
            end
        end
        if (result.valid) begin
            r_res_value[r_res_wr]  <= result.value;
            r_res_status[r_res_wr] <= result.status;
        end
    end

endmodule

@@ rtl/pfs_counter_bank.sv @@
module pfs_counter_bank #(
    parameter int NUM_PORTS = pfs_pkg::DEF_NUM_PORTS,
    localparam int ADDR_W = $clog2(NUM_PORTS * pfs_pkg::CNT_PER_PORT)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfs_pkg::t_op_ctl   i_op_ctl,
    input  logic [ADDR_W-1:0]  i_op_addr,
    output pfs_pkg::t_result   o_result,
    output logic               o_clearing
);
    import pfs_pkg::*;

    localparam int DEPTH = NUM_PORTS * CNT_PER_PORT;

    logic [63:0]       r_mem [DEPTH];
    logic [63:0]       r_rdata;

    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_s1_valid;
    t_op_ctl           r_s1_ctl;
    logic [ADDR_W-1:0] r_s1_addr;

    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [63:0]       r_fwd_data;

    logic [63:0]       base;
    logic [63:0]       sum;
    logic              s1_write;

    // Memory: one write port shared by the clearing pass and the update stage.
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= '0;
        end else if (s1_write) begin
            r_mem[r_s1_addr] <= sum;
        end
        r_rdata <= r_mem[i_op_addr];
    end

    // Clearing pass after reset zeroes every counter, one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_active <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // The write of the previous update lands on the same edge as this read,
    // so a hit on that address takes the freshly written value instead.
    always_comb begin
        base = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rdata;
        sum  = base + {48'd0, r_s1_ctl.amount};
        s1_write = r_s1_valid && !r_s1_ctl.is_read;
    end

    // Update stage and forwarding registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_op_ctl.valid;
            r_fwd_valid <= s1_write;
        end
        r_s1_ctl   <= i_op_ctl;
        r_s1_addr  <= i_op_addr;
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= sum;
    end

    // Read results leave straight from the update stage.
    always_comb begin
        o_result.valid  = r_s1_valid && r_s1_ctl.is_read;
        o_result.status = r_s1_ctl.status;
        o_result.value  = r_s1_ctl.zero ? 64'd0 : base;
        o_clearing      = r_clr_active;
    end

endmodule

@@ bench/frame_stats_scoreboard_pkg.sv @@
`timescale 1ns / 100ps

package frame_stats_scoreboard_pkg;

    import pfs_pkg::*;

    localparam int N_COUNTERS = DEF_NUM_PORTS * CNT_PER_PORT;
    localparam int MAX_REPORTED = 10;

    // One counter read as the block should return it.
    typedef struct packed {
        logic [63:0] value;
        logic        status;
    } t_read_result;

    // Tracks the counters of every port and checks counter reads against them.
    class t_frame_stats_scoreboard;

        logic [63:0]  counter_image [N_COUNTERS];
        logic [15:0]  frame_len;
        logic [15:0]  frame_ethertype;
        logic [7:0]   frame_proto;
        logic [3:0]   active_ports;
        t_read_result pending_reads [$];
        int           mismatches;

        function new();
            foreach (counter_image[i]) counter_image[i] = '0;
            frame_len       = '0;
            frame_ethertype = '0;
            frame_proto     = '0;
            active_ports    = '0;
            mismatches      = 0;
        endfunction

        function void set_active_ports(logic [3:0] value);
            active_ports = value;
        endfunction

        function int outstanding();
            return pending_reads.size();
        endfunction

        function logic port_active(logic [2:0] port);
            return (port < active_ports) && (int'(port) < DEF_NUM_PORTS);
        endfunction

        // Transmit counters sit at the even slot of each pair, receive at the odd one.
        function void bump(logic [2:0] port, logic [4:0] kind, logic tx, logic [63:0] amount);
            int slot;
            slot = int'(port) * CNT_PER_PORT + int'(kind) + (tx ? 0 : 1);
            counter_image[slot] += amount;
        endfunction

        // Count a finished frame and classify it by EtherType and protocol.
        function void close_frame(logic [2:0] port, logic tx, logic [15:0] len);
            logic [7:0] proto;
            proto = '0;
            bump(port, K_PACKETS, tx, 64'd1);
            bump(port, K_BYTES, tx, 64'(len));
            if (len < LEN_L2_MIN) return;
            if (frame_ethertype == ETH_ARP) begin
                bump(port, K_ARP, tx, 64'd1);
                return;
            end
            if (frame_ethertype == ETH_IPV4) begin
                bump(port, K_IPV4, tx, 64'd1);
                if (len >= LEN_V4_MIN) proto = frame_proto;
            end else if (frame_ethertype == ETH_IPV6) begin
                bump(port, K_IPV6, tx, 64'd1);
                if (len >= LEN_V6_MIN) proto = frame_proto;
            end else begin
                return;
            end
            if (proto == PROTO_ICMP || proto == PROTO_ICMP6) begin
                bump(port, K_ICMP, tx, 64'd1);
            end else if (proto == PROTO_TCP) begin
                bump(port, K_TCP, tx, 64'd1);
            end else if (proto == PROTO_UDP) begin
                bump(port, K_UDP, tx, 64'd1);
            end
        endfunction

        // Apply one accepted request; a read leaves the value it must return.
        function void apply_request(t_mode mode, logic [2:0] port, logic dir,
                                    logic [7:0] data, logic last, logic [4:0] sel);
            t_read_result expected_read;
            logic [15:0]  pos;
            if (mode == MODE_READ) begin
                expected_read.value  = '0;
                expected_read.status = 1'b1;
                if (port_active(port)) begin
                    expected_read.status = 1'b0;
                    if (sel < CNT_PER_PORT)
                        expected_read.value = counter_image[int'(port) * CNT_PER_PORT + int'(sel)];
                end
                pending_reads.push_back(expected_read);
                return;
            end
            if (!port_active(port)) return;
            case (mode)
                MODE_ERROR: begin
                    bump(port, K_ERRORS, dir, 64'd1);
                end
                MODE_DROP: begin
                    bump(port, K_DROPPED, dir, 64'd1);
                end
                default: begin
                    // One frame is in progress whatever port its bytes carry.
                    pos = frame_len;
                    if (pos == POS_ETH_HI)
                        frame_ethertype[15:8] = data;
                    else if (pos == POS_ETH_LO)
                        frame_ethertype[7:0] = data;
                    else if (pos == POS_V4_PROTO && frame_ethertype == ETH_IPV4)
                        frame_proto = data;
                    else if (pos == POS_V6_NEXT && frame_ethertype == ETH_IPV6)
                        frame_proto = data;
                    frame_len = (pos == 16'hFFFF) ? pos : pos + 16'd1;
                    if (last) begin
                        close_frame(port, dir, frame_len);
                        frame_len       = '0;
                        frame_ethertype = '0;
                        frame_proto     = '0;
                    end
                end
            endcase
        endfunction

        // Compare a returned read with the oldest outstanding one.
        function void check_read_result(logic [63:0] value, logic status);
            t_read_result expected_read;
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("read result with no read outstanding: value %h status %0d",
                             value, status);
                return;
            end
            expected_read = pending_reads.pop_front();
            if (value !== expected_read.value || status !== expected_read.status) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("read mismatch: expected value %h status %0d, got value %h status %0d",
                             expected_read.value, expected_read.status, value, status);
            end
        endfunction

    endclass

endpackage

@@ bench/tb_per_port_frame_statistics_top.sv @@
`timescale 1ns / 100ps

module tb_per_port_frame_statistics_top;

    import pfs_pkg::*;
    import frame_stats_scoreboard_pkg::*;

    localparam logic [2:0] ADDR_ACTIVE_PORTS = 3'd0;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_REQUESTS = 20;
    localparam int RUN_LIMIT_NS = 20_000_000;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = '0;
    logic [2:0]  i_port_index = '0;
    logic        i_direction = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic [4:0]  i_counter_select = '0;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    logic [63:0] o_read_value;
    logic        o_read_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_frame_stats_scoreboard sb;
    logic [3:0] active_now = '0;
    logic       source_holding = 1'b0;
    logic       steady_source = 1'b0;
    logic       steady_sink = 1'b0;
    int         sink_hold = 0;
    int         requests_sent = 0;

    per_port_frame_statistics_top #(
        .NUM_PORTS(DEF_NUM_PORTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_port_index    (i_port_index),
        .i_direction     (i_direction),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_counter_select(i_counter_select),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_read_value    (o_read_value),
        .o_read_status   (o_read_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit on the run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Idle stretches: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Frame lengths cluster around the classification thresholds.
    function automatic int pick_length();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            len = $urandom_range(1, 13);
        end else if (r < 80) begin
            case ($urandom_range(0, 4))
                0: len = 14;
                1: len = 33;
                2: len = 34;
                3: len = 53;
                default: len = 54;
            endcase
        end else begin
            len = $urandom_range(15, 64);
        end
        return len;
    endfunction

    // Mostly ports that are registered, sometimes any port.
    function automatic logic [2:0] pick_port();
        if (active_now != 0 && $urandom_range(0, 99) < 80)
            return 3'($urandom_range(0, int'(active_now) - 1));
        return 3'($urandom_range(0, 7));
    endfunction

    // Result side: check every accepted read and stall at random.
    always @(posedge i_clk) begin
        if (o_res_valid && i_res_ready)
            sb.check_read_result(o_read_value, o_read_status);
        if (sink_hold > 0) begin
            i_res_ready <= 1'b0;
            sink_hold--;
        end else begin
            i_res_ready <= 1'b1;
            if (!steady_sink && $urandom_range(0, 99) < 30)
                sink_hold = pick_gap();
        end
    end

    // Drop valid if a request is still being presented.
    task automatic release_source();
        if (source_holding) begin
            i_valid <= 1'b0;
            source_holding = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Hold the request side until every outstanding read has returned.
    task automatic pause_for_results();
        release_source();
        @(posedge i_clk);
        wait_drained();
    endtask

    // Present one request and wait until the block takes it.
    task automatic put_request(input t_mode mode, input logic [2:0] port, input logic dir,
                               input logic [7:0] data, input logic last,
                               input logic [4:0] sel);
        int gap;
        gap = steady_source ? 0 : pick_gap();
        if (gap > 0) begin
            release_source();
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_mode           <= mode;
        i_port_index     <= port;
        i_direction      <= dir;
        i_data_byte      <= data;
        i_last_byte      <= last;
        i_counter_select <= sel;
        source_holding = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.apply_request(mode, port, dir, data, last, sel);
        requests_sent++;
    endtask

    task automatic put_read(input logic [2:0] port, input logic [4:0] sel);
        put_request(MODE_READ, port, 1'($urandom), 8'($urandom), 1'($urandom), sel);
    endtask

    // An error, drop or read slipped in between frame bytes.
    task automatic put_side_request();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            put_request(MODE_ERROR, pick_port(), 1'($urandom), 8'($urandom), 1'($urandom),
                        5'($urandom));
        else if (r == 1)
            put_request(MODE_DROP, pick_port(), 1'($urandom), 8'($urandom), 1'($urandom),
                        5'($urandom));
        else
            put_read(pick_port(), 5'($urandom));
    endtask

    // Send one frame; with mess_pct > 0 other requests and stray ports are mixed in.
    task automatic send_frame(input logic [2:0] port, input logic dir, input int len,
                              input logic [15:0] ethertype, input logic [7:0] proto,
                              input int mess_pct);
        logic [7:0] b;
        logic [2:0] byte_port;
        logic       byte_dir;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i == int'(POS_ETH_HI))
                b = ethertype[15:8];
            else if (i == int'(POS_ETH_LO))
                b = ethertype[7:0];
            else if (i == int'(POS_V4_PROTO) && ethertype == ETH_IPV4)
                b = proto;
            else if (i == int'(POS_V6_NEXT) && ethertype == ETH_IPV6)
                b = proto;
            byte_port = port;
            byte_dir  = dir;
            if (i != len - 1 && $urandom_range(0, 99) < mess_pct) begin
                byte_port = 3'($urandom);
                byte_dir  = 1'($urandom);
            end
            if ($urandom_range(0, 99) < mess_pct)
                put_side_request();
            put_request(MODE_FRAME, byte_port, byte_dir, b, i == len - 1, 5'($urandom));
        end
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_ACTIVE_PORTS) begin
            active_now = value[3:0];
            sb.set_active_ports(value[3:0]);
        end
    endtask

    // Random frame with a known or random EtherType and protocol.
    task automatic send_random_frame();
        logic [15:0] ethertype;
        logic [7:0]  proto;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 25) ethertype = ETH_ARP;
        else if (r < 55) ethertype = ETH_IPV4;
        else if (r < 85) ethertype = ETH_IPV6;
        else ethertype = 16'($urandom);
        case ($urandom_range(0, 4))
            0: proto = ($urandom_range(0, 1) != 0) ? PROTO_ICMP : PROTO_ICMP6;
            1: proto = PROTO_TCP;
            2: proto = PROTO_UDP;
            default: proto = 8'($urandom);
        endcase
        send_frame(pick_port(), 1'($urandom), pick_length(), ethertype, proto,
                   ($urandom_range(0, 2) == 0) ? 10 : 0);
    endtask

    // One phase of mixed traffic: mostly whole frames, some reads, events and noise.
    task automatic run_random_phase(input int target);
        int start;
        int r;
        start = requests_sent;
        while (requests_sent - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_random_frame();
            else if (r < 72)
                put_read(pick_port(), 5'($urandom));
            else if (r < 84)
                put_side_request();
            else if (r < 98)
                put_request(t_mode'($urandom_range(0, 3)), 3'($urandom), 1'($urandom),
                            8'($urandom), 1'($urandom), 5'($urandom));
            else
                pause_for_results();
        end
    endtask

    // Reconfigure only once the block is idle.
    task automatic reconfigure(input logic [3:0] ports);
        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_write(ADDR_ACTIVE_PORTS, 32'(ports));
    endtask

    // Main sequence.
    initial begin
        logic [3:0] phase_ports [5];
        sb = new();
        phase_ports = '{4'd3, 4'd0, 4'd1, 4'd5, 4'd8};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_write(ADDR_ACTIVE_PORTS, 32'd8);

        // Directed: reads of fresh counters and out-of-range selects; errors and drops.
        put_read(3'd0, K_PACKETS);
        put_read(3'd7, 5'd31);
        put_read(3'd3, 5'd20);
        put_request(MODE_ERROR, 3'd7, 1'b1, 8'hFF, 1'b1, 5'd0);
        put_request(MODE_ERROR, 3'd0, 1'b0, 8'h00, 1'b0, 5'd31);
        put_request(MODE_DROP, 3'd0, 1'b0, 8'h00, 1'b0, 5'd0);
        put_request(MODE_DROP, 3'd7, 1'b1, 8'hFF, 1'b1, 5'd31);

        // Directed frames: too short to classify, ARP, IP at and below the thresholds.
        send_frame(3'd1, 1'b1, 5, 16'h0000, 8'h00, 0);
        send_frame(3'd2, 1'b0, 14, ETH_ARP, 8'h00, 0);
        send_frame(3'd3, 1'b1, 34, ETH_IPV4, PROTO_TCP, 0);
        send_frame(3'd3, 1'b0, 33, ETH_IPV4, PROTO_UDP, 0);
        send_frame(3'd4, 1'b0, 54, ETH_IPV6, PROTO_ICMP6, 0);
        send_frame(3'd4, 1'b1, 53, ETH_IPV6, PROTO_TCP, 0);
        send_frame(3'd5, 1'b1, 16, 16'h1234, PROTO_TCP, 0);

        // Interleaved frame: other ports and other requests mid-frame, ends on port 5.
        for (int i = 0; i < 14; i++) begin
            if (i == 5) put_request(MODE_ERROR, 3'd2, 1'b1, 8'h00, 1'b0, 5'd0);
            if (i == 7) put_request(MODE_DROP, 3'd6, 1'b0, 8'h00, 1'b1, 5'd0);
            if (i == 8) put_read(3'd1, K_PACKETS);
            put_request(MODE_FRAME, (i == 13) ? 3'd5 : ((i == 9) ? 3'd6 : 3'd1),
                        (i == 13) ? 1'b0 : 1'b1,
                        (i == 12) ? ETH_ARP[15:8] : ((i == 13) ? ETH_ARP[7:0] : 8'(i)),
                        i == 13, 5'd0);
        end
        put_read(3'd5, K_ARP + 5'd1);

        // Random phases over several port counts.
        foreach (phase_ports[p]) begin
            reconfigure(phase_ports[p]);
            steady_source = ($urandom_range(0, 3) == 0);
            steady_sink   = ($urandom_range(0, 3) == 0);
            run_random_phase(PHASE_REQUESTS);
        end
        steady_source = 1'b0;
        steady_sink   = 1'b0;

        // Read back every counter of every port.
        for (int p = 0; p < DEF_NUM_PORTS; p++)
            for (int s = 0; s < CNT_PER_PORT; s++)
                put_read(3'(p), 5'(s));

        release_source();
        @(posedge i_clk);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
